// File: rtl/qrtm_pkg.sv
package qrtm_pkg;

   localparam int unsigned SpeedW    = 16;
   localparam int unsigned SqW       = 32;
   localparam int unsigned ThrustW   = 34;
   localparam int unsigned TorqueW   = 44;
   localparam int unsigned ParamW    = 16;
   localparam int unsigned CoefW     = 20;
   localparam int unsigned TermW     = 52;
   localparam int unsigned AccW      = 55;
   localparam int unsigned WinW      = 6;
   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned CsrDataW  = 16;
   localparam int unsigned NumRotors = 4;
   localparam int unsigned NumTerms  = 12;

   localparam int unsigned WindowMaxDefault = 32;

   localparam logic [WinW-1:0]   WindowLenReset = 6'd20;
   localparam logic [ParamW-1:0] ThrustCoefReset = 16'd26624;
   localparam logic [ParamW-1:0] DragRatioReset  = 16'd205;
   localparam logic [ParamW-1:0] ArmXReset       = 16'd614;
   localparam logic [ParamW-1:0] ArmYOuterReset  = 16'd1024;
   localparam logic [ParamW-1:0] ArmYInnerReset  = 16'd778;

   typedef enum logic [CsrIdxW-1:0] {
      REG_WINDOW_LEN  = 3'd0,
      REG_THRUST_COEF = 3'd1,
      REG_DRAG_RATIO  = 3'd2,
      REG_ARM_X       = 3'd3,
      REG_ARM_Y_OUTER = 3'd4,
      REG_ARM_Y_INNER = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      COEF_OUTER = 2'd0,
      COEF_INNER = 2'd1,
      COEF_X     = 2'd2,
      COEF_DRAG  = 2'd3
   } coef_sel_type;

   typedef struct packed {
      logic [WinW-1:0]   window_len;
      logic [ParamW-1:0] thrust_coef;
      logic [ParamW-1:0] drag_ratio;
      logic [ParamW-1:0] arm_x;
      logic [ParamW-1:0] arm_y_outer;
      logic [ParamW-1:0] arm_y_inner;
   } cfg_type;

   typedef struct packed {
      logic [NumRotors-1:0][SqW-1:0] sq;
      logic [ThrustW-1:0]            thrust;
   } tick_type;

   // Term t covers axis t/4 and rotor t%4.
   function automatic coef_sel_type term_coef(input logic [3:0] term);
      coef_sel_type sel;
      case (term)
         4'd0, 4'd2:  sel = COEF_OUTER;
         4'd1, 4'd3:  sel = COEF_INNER;
         4'd4, 4'd5, 4'd6, 4'd7: sel = COEF_X;
         default:     sel = COEF_DRAG;
      endcase
      return sel;
   endfunction

   function automatic logic term_neg(input logic [3:0] term);
      logic neg;
      case (term)
         4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd11: neg = 1'b1;
         default: neg = 1'b0;
      endcase
      return neg;
   endfunction

endpackage

// File: rtl/qrtm_if.sv
interface qrtm_req_if;
   logic                           valid;
   logic                           ready;
   logic [qrtm_pkg::SpeedW-1:0]    rotor_speed_a;
   logic [qrtm_pkg::SpeedW-1:0]    rotor_speed_b;
   logic [qrtm_pkg::SpeedW-1:0]    rotor_speed_c;
   logic [qrtm_pkg::SpeedW-1:0]    rotor_speed_d;

   modport source (output valid, rotor_speed_a, rotor_speed_b, rotor_speed_c,
                   rotor_speed_d, input ready);
   modport sink   (input valid, rotor_speed_a, rotor_speed_b, rotor_speed_c,
                   rotor_speed_d, output ready);
endinterface

interface qrtm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [qrtm_pkg::TorqueW-1:0] avg_torque_x;
   logic signed [qrtm_pkg::TorqueW-1:0] avg_torque_y;
   logic signed [qrtm_pkg::TorqueW-1:0] avg_torque_z;
   logic [qrtm_pkg::ThrustW-1:0]        total_thrust;

   modport source (output valid, avg_torque_x, avg_torque_y, avg_torque_z,
                   total_thrust, input ready);
   modport sink   (input valid, avg_torque_x, avg_torque_y, avg_torque_z,
                   total_thrust, output ready);
endinterface

// File: rtl/qrtm_front.sv
module qrtm_front (
   input  logic                clock,
   input  logic                reset,
   qrtm_req_if.sink            req_ch,
   input  logic                q_full,
   output logic                q_push,
   output qrtm_pkg::tick_type  q_data
);

   typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_PUSH} state_type;

   state_type state_ff, state_in;
   logic [qrtm_pkg::NumRotors-1:0][qrtm_pkg::SpeedW-1:0] speed_ff, speed_in;
   logic [1:0] step_ff, step_in;
   qrtm_pkg::tick_type tick_ff, tick_in;
   logic [qrtm_pkg::SqW-1:0] sq;

   assign req_ch.ready = (state_ff == F_IDLE);
   assign sq = speed_ff[step_ff] * speed_ff[step_ff];
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_data = tick_ff;

   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      step_in  = step_ff;
      tick_in  = tick_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               speed_in = {req_ch.rotor_speed_d, req_ch.rotor_speed_c,
                           req_ch.rotor_speed_b, req_ch.rotor_speed_a};
               step_in  = 2'd0;
               tick_in.thrust = '0;
               state_in = F_SQUARE;
            end
         end
         F_SQUARE: begin
            tick_in.sq[step_ff] = sq;
            tick_in.thrust = tick_ff.thrust + qrtm_pkg::ThrustW'(sq);
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      speed_ff <= speed_in;
      step_ff  <= step_in;
      tick_ff  <= tick_in;
   end

endmodule

// File: rtl/qrtm_queue.sv
module qrtm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qrtm_pkg::tick_type  push_data,
   input  logic                pop,
   output qrtm_pkg::tick_type  pop_data,
   output logic                full,
   output logic                empty
);

   qrtm_pkg::tick_type entry_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/qrtm_back.sv
module qrtm_back #(
   parameter int unsigned WINDOW_MAX = qrtm_pkg::WindowMaxDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  qrtm_pkg::cfg_type   cfg,
   input  logic                q_empty,
   input  qrtm_pkg::tick_type  q_data,
   output logic                q_pop,
   qrtm_rsp_if.source          rsp_ch
);

   localparam int unsigned IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);
   localparam int unsigned LenW = (CntW > qrtm_pkg::WinW) ? CntW : qrtm_pkg::WinW;
   localparam int unsigned SumW = qrtm_pkg::TorqueW + CntW;
   localparam int unsigned DivCntW = $clog2(SumW + 1);
   localparam int unsigned TW = qrtm_pkg::TorqueW;

   typedef enum logic [2:0] {
      B_IDLE, B_COEF, B_TERM, B_READ, B_UPDATE, B_DIV, B_DONE
   } state_type;

   state_type state_ff;
   qrtm_pkg::tick_type tick_ff;
   logic [3:0][qrtm_pkg::CoefW-1:0] coef_ff;
   logic [3:0] step_ff;
   logic [qrtm_pkg::TermW-1:0] prod_ff;
   logic prod_neg_ff, prod_vld_ff;
   logic [1:0] prod_axis_ff;
   logic signed [2:0][qrtm_pkg::AccW-1:0] acc_ff;
   logic signed [2:0][TW-1:0] torque_ff;
   logic [3*TW-1:0] ring [WINDOW_MAX];
   logic [3*TW-1:0] old_ff;
   logic evict_ff;
   logic signed [2:0][SumW-1:0] sum_ff;
   logic [IdxW-1:0] slot_ff;
   logic [CntW-1:0] fill_ff;
   logic [2:0][SumW-1:0] quo_ff;
   logic [2:0][CntW-1:0] rem_ff;
   logic [2:0] neg_ff;
   logic [DivCntW-1:0] div_cnt_ff;
   logic rsp_valid_ff;
   logic signed [2:0][TW-1:0] avg_ff;
   logic [qrtm_pkg::ThrustW-1:0] thrust_ff;

   // Coefficient products, one per cycle.
   logic [qrtm_pkg::ParamW-1:0] arm_sel;
   logic [2*qrtm_pkg::ParamW-1:0] coef_mul;
   always_comb begin
      case (step_ff[1:0])
         2'd0:    arm_sel = cfg.arm_y_outer;
         2'd1:    arm_sel = cfg.arm_y_inner;
         2'd2:    arm_sel = cfg.arm_x;
         default: arm_sel = cfg.drag_ratio;
      endcase
   end
   assign coef_mul = cfg.thrust_coef * arm_sel;

   // Per-rotor torque terms.
   qrtm_pkg::coef_sel_type tsel;
   logic [qrtm_pkg::TermW-1:0] term_mul;
   assign tsel = qrtm_pkg::term_coef(step_ff);
   assign term_mul = qrtm_pkg::TermW'(coef_ff[tsel] * tick_ff.sq[step_ff[1:0]]);

   // Window bookkeeping.
   logic [LenW-1:0] wl_ext, len;
   logic [CntW:0] old_wide;
   logic [IdxW-1:0] oldest;
   assign wl_ext = LenW'(cfg.window_len);
   always_comb begin
      if (wl_ext == '0) begin
         len = LenW'(1);
      end else if (wl_ext > LenW'(WINDOW_MAX)) begin
         len = LenW'(WINDOW_MAX);
      end else begin
         len = wl_ext;
      end
      if ((CntW + 1)'(slot_ff) >= (CntW + 1)'(fill_ff)) begin
         old_wide = (CntW + 1)'(slot_ff) - (CntW + 1)'(fill_ff);
      end else begin
         old_wide = (CntW + 1)'(slot_ff) + (CntW + 1)'(WINDOW_MAX)
                    - (CntW + 1)'(fill_ff);
      end
      oldest = old_wide[IdxW-1:0];
   end

   logic signed [2:0][SumW-1:0] sum_new;
   logic signed [2:0][TW-1:0] old_t;
   logic [CntW-1:0] fill_new;
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         old_t[a] = old_ff[a*TW +: TW];
         sum_new[a] = sum_ff[a] + SumW'($signed(torque_ff[a]))
                      - (evict_ff ? SumW'($signed(old_t[a])) : SumW'(0));
      end
      fill_new = fill_ff + CntW'(1) - (evict_ff ? CntW'(1) : CntW'(0));
   end

   // One restoring division step per lane.
   logic [2:0][CntW:0] trial;
   logic [2:0] qbit;
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         trial[a] = {rem_ff[a], quo_ff[a][SumW-1]};
         qbit[a]  = trial[a] >= (CntW + 1)'(fill_ff);
      end
   end

   assign q_pop = (state_ff == B_IDLE) && !q_empty;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.avg_torque_x = avg_ff[0];
   assign rsp_ch.avg_torque_y = avg_ff[1];
   assign rsp_ch.avg_torque_z = avg_ff[2];
   assign rsp_ch.total_thrust = thrust_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_ff       <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         prod_vld_ff  <= 1'b0;
      end else begin
         if (rsp_ch.ready && state_ff != B_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  tick_ff  <= q_data;
                  step_ff  <= '0;
                  acc_ff   <= '0;
                  state_ff <= B_COEF;
               end
            end
            B_COEF: begin
               coef_ff[step_ff[1:0]] <= coef_mul[12 +: qrtm_pkg::CoefW];
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd3) begin
                  step_ff  <= '0;
                  state_ff <= B_TERM;
               end
            end
            B_TERM: begin
               prod_ff      <= term_mul;
               prod_neg_ff  <= qrtm_pkg::term_neg(step_ff);
               prod_axis_ff <= step_ff[3:2];
               prod_vld_ff  <= (step_ff < 4'(qrtm_pkg::NumTerms));
               if (prod_vld_ff) begin
                  acc_ff[prod_axis_ff] <= prod_neg_ff
                     ? acc_ff[prod_axis_ff] - qrtm_pkg::AccW'(prod_ff)
                     : acc_ff[prod_axis_ff] + qrtm_pkg::AccW'(prod_ff);
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(qrtm_pkg::NumTerms)) begin
                  state_ff <= B_READ;
               end
            end
            B_READ: begin
               prod_vld_ff <= 1'b0;
               for (int a = 0; a < 3; a++) begin
                  torque_ff[a] <= TW'($signed(acc_ff[a]) >>> 12);
               end
               evict_ff <= (LenW'(fill_ff) >= len);
               state_ff <= B_UPDATE;
            end
            B_UPDATE: begin
               sum_ff  <= sum_new;
               fill_ff <= fill_new;
               slot_ff <= (slot_ff == IdxW'(WINDOW_MAX - 1)) ? '0 : slot_ff + IdxW'(1);
               for (int a = 0; a < 3; a++) begin
                  neg_ff[a] <= sum_new[a][SumW-1];
                  quo_ff[a] <= sum_new[a][SumW-1] ? -sum_new[a] : sum_new[a];
                  rem_ff[a] <= '0;
               end
               div_cnt_ff <= '0;
               state_ff   <= B_DIV;
            end
            B_DIV: begin
               for (int a = 0; a < 3; a++) begin
                  rem_ff[a] <= qbit[a] ? CntW'(trial[a] - (CntW + 1)'(fill_ff))
                                       : CntW'(trial[a]);
                  quo_ff[a] <= {quo_ff[a][SumW-2:0], qbit[a]};
               end
               div_cnt_ff <= div_cnt_ff + DivCntW'(1);
               if (div_cnt_ff == DivCntW'(SumW - 1)) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  for (int a = 0; a < 3; a++) begin
                     avg_ff[a] <= neg_ff[a] ? -quo_ff[a][TW-1:0] : quo_ff[a][TW-1:0];
                  end
                  thrust_ff    <= tick_ff.thrust;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // Torque ring: written once per tick, oldest entry read ahead of the update.
   always_ff @(posedge clock) begin
      old_ff <= ring[oldest];
      if (state_ff == B_UPDATE) begin
         ring[slot_ff] <= {torque_ff[2], torque_ff[1], torque_ff[0]};
      end
   end

endmodule

// File: rtl/quad_rotor_torque_mixer_avg.sv
// Quadrotor torque mixer with a moving-average torque output.
// A transaction on req_ch carries four rotor speeds (unsigned Q8.8). For each
// one the block returns exactly one transaction on rsp_ch with the averaged
// roll, pitch and yaw torques (signed Q28.16) and the unfiltered thrust.
// The csr_ port writes the six configuration registers by index; it should
// only be used while no transaction is in flight.
// A front stage squares the speeds on one multiplier and pushes them into a
// two-entry queue. The back stage forms the coefficient products, the twelve
// torque terms, updates the ring and the running sums and divides by the fill
// count one quotient bit per cycle. The back stage, mostly its divider, sets
// the sustained rate of transactions.
// The result sits in an output register; while the receiver stalls, the back
// stage holds its finished result and the front stage and queue keep taking
// up to three more requests. Reset is synchronous and empties the window.
module quad_rotor_torque_mixer_avg #(
   parameter int unsigned WINDOW_MAX = qrtm_pkg::WindowMaxDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   qrtm_req_if.sink                        req_ch,
   qrtm_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [qrtm_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [qrtm_pkg::CsrDataW-1:0]   csr_wdata
);

   qrtm_pkg::cfg_type  cfg_ff;
   qrtm_pkg::tick_type push_data, pop_data;
   logic push, pop, full, empty;

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len  <= qrtm_pkg::WindowLenReset;
         cfg_ff.thrust_coef <= qrtm_pkg::ThrustCoefReset;
         cfg_ff.drag_ratio  <= qrtm_pkg::DragRatioReset;
         cfg_ff.arm_x       <= qrtm_pkg::ArmXReset;
         cfg_ff.arm_y_outer <= qrtm_pkg::ArmYOuterReset;
         cfg_ff.arm_y_inner <= qrtm_pkg::ArmYInnerReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            qrtm_pkg::REG_WINDOW_LEN:  cfg_ff.window_len  <= csr_wdata[qrtm_pkg::WinW-1:0];
            qrtm_pkg::REG_THRUST_COEF: cfg_ff.thrust_coef <= csr_wdata;
            qrtm_pkg::REG_DRAG_RATIO:  cfg_ff.drag_ratio  <= csr_wdata;
            qrtm_pkg::REG_ARM_X:       cfg_ff.arm_x       <= csr_wdata;
            qrtm_pkg::REG_ARM_Y_OUTER: cfg_ff.arm_y_outer <= csr_wdata;
            qrtm_pkg::REG_ARM_Y_INNER: cfg_ff.arm_y_inner <= csr_wdata;
            default: ;
         endcase
      end
   end

   qrtm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (full),
      .q_push (push),
      .q_data (push_data)
   );

   qrtm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   qrtm_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (empty),
      .q_data  (pop_data),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
